FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of the broadcast source offset block.
// Standalone header; the assertion bodies drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define BSO_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("bso assertion failed");
// Expression must never be true outside reset.
`define BSO_ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("bso forbidden condition");
`else
`define BSO_ASSERT(label, clk, rstn, prop)
`define BSO_ASSERT_NEVER(label, clk, rstn, expr)
`endif

`endif

FILE: sv/bso_pkg.sv
// Package for the broadcast source offset block: widths, pipeline sizing
// and configuration register codes. No dependencies.
package bso_pkg;

    // Number of tensor dimensions walked per index (1 to 8).
    localparam int NUM_DIMS  = 4;
    // Dimensions that own an extent and a stride register.
    localparam int REG_DIMS  = 4;

    localparam int INDEX_W   = 32;                  // linear index width
    localparam int CFG_W     = 31;                  // extent / stride width
    localparam int CFG_IDX_W = $clog2(2 * REG_DIMS); // register index width
    localparam int SLOT_W    = $clog2(REG_DIMS);    // per-dimension slot width

    // One quotient bit per divider stage.
    localparam int DIV_STEPS = INDEX_W;
    localparam int DIV_TOTAL = NUM_DIMS * DIV_STEPS;
    // Divider stages, then a product stage and an accumulate stage.
    localparam int STAGES    = DIV_TOTAL + 2;

    // Register index codes: extents first, then strides.
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_BASE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_BASE = CFG_IDX_W'(REG_DIMS);
    localparam int                   CFG_LIMIT       = 2 * REG_DIMS;

endpackage

FILE: sv/broadcast_source_offset.sv
// Broadcast source offset: maps a linear output-tensor index to the linear
// source index of a broadcast. Depends on bso_pkg and assert_macros.svh.
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  -----------------------
//  input     in         s_valid / s_ready         s_out_index  [31:0]
//  result    out        m_valid / m_ready         m_src_index  [31:0]
//  config    in         cfg_wr_en (no wait)       cfg_wr_index, cfg_wr_data
//
// One word is accepted per cycle while the skid register is empty, and one
// result leaves per cycle while m_ready is high. The depth is set by the
// restoring divider that resolves one quotient bit per stage for every
// dimension, followed by a multiply stage, an accumulate stage and the output
// register. Reset (aresetn low at a clock edge) empties the pipeline and sets
// every extent to one and every stride to zero. When the result side stalls,
// a skid register catches the word in flight and the whole pipeline stays
// frozen while the skid register is full, so nothing is dropped or repeated.

`include "assert_macros.svh"

module broadcast_source_offset (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic [bso_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [bso_pkg::CFG_W-1:0]       cfg_wr_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [bso_pkg::INDEX_W-1:0]     s_out_index,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bso_pkg::INDEX_W-1:0]     m_src_index
);
    import bso_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. A zero extent behaves as one, so it is
    // stored as one and the divider never sees a zero divisor.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] extent_reg [REG_DIMS];
    logic [CFG_W-1:0] stride_reg [REG_DIMS];
    logic [CFG_W-1:0] cfg_extent_value;
    logic [SLOT_W-1:0] cfg_slot;

    assign cfg_extent_value = (cfg_wr_data == '0) ? CFG_W'(1) : cfg_wr_data;
    assign cfg_slot         = cfg_wr_index[SLOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_DIMS; i++) begin
                extent_reg[i] <= CFG_W'(1);
                stride_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            if (cfg_wr_index < CFG_STRIDE_BASE) begin
                extent_reg[cfg_slot] <= cfg_extent_value;
            end else if (32'(cfg_wr_index) < CFG_LIMIT) begin
                stride_reg[cfg_slot] <= cfg_wr_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline. The whole pipeline advances together on pipe_en; valid
    // bits shift alongside the data.
    //   rem : running remainder of the current dimension's division
    //   dq  : dividend bits still to consume, quotient bits shifted in
    //   prod: coordinate times stride of the dimension just finished
    //   acc : running source offset, wrapping at 32 bits
    // ------------------------------------------------------------------
    logic                pipe_en;
    logic [STAGES-1:0]   valid_reg;
    logic [CFG_W-1:0]    rem_reg  [STAGES];
    logic [INDEX_W-1:0]  dq_reg   [STAGES];
    logic [INDEX_W-1:0]  prod_reg [STAGES];
    logic [INDEX_W-1:0]  acc_reg  [STAGES];

    logic                skid_valid_reg;
    logic [INDEX_W-1:0]  skid_data_reg;
    logic                out_valid_reg;
    logic [INDEX_W-1:0]  out_data_reg;

    assign pipe_en = !skid_valid_reg;
    assign s_ready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (pipe_en) begin
            valid_reg <= {valid_reg[STAGES-2:0], s_valid};
        end
    end

    for (genvar k = 0; k < STAGES; k++) begin : gen_stage
        localparam int  DIM      = k / DIV_STEPS;
        localparam int  STEP     = k % DIV_STEPS;
        localparam bit  IS_DIV   = (k < DIV_TOTAL);
        localparam bit  IS_PROD  = (STEP == 0) && (DIM > 0);
        localparam bit  IS_ADD   = (STEP == 1) && (DIM > 0);

        logic [CFG_W-1:0]   rem_prev;
        logic [INDEX_W-1:0] dq_prev;
        logic [INDEX_W-1:0] prod_prev;
        logic [INDEX_W-1:0] acc_prev;
        logic [CFG_W-1:0]   divisor;
        logic [CFG_W-1:0]   stride;
        logic [CFG_W-1:0]   rem_next;
        logic [INDEX_W-1:0] dq_next;
        logic [INDEX_W-1:0] prod_next;
        logic [INDEX_W-1:0] acc_next;

        if (k == 0) begin : gen_head
            assign rem_prev  = '0;
            assign dq_prev   = s_out_index;
            assign prod_prev = '0;
            assign acc_prev  = '0;
        end else begin : gen_link
            assign rem_prev  = rem_reg[k-1];
            assign dq_prev   = dq_reg[k-1];
            assign prod_prev = prod_reg[k-1];
            assign acc_prev  = acc_reg[k-1];
        end

        // Dimensions without registers divide by one.
        if (IS_DIV && (DIM < REG_DIMS)) begin : gen_div_reg
            assign divisor = extent_reg[DIM];
        end else begin : gen_div_one
            assign divisor = CFG_W'(1);
        end

        // The product of dimension DIM-1 is formed while dimension DIM starts.
        if (IS_PROD && (DIM - 1 < REG_DIMS)) begin : gen_stride_reg
            assign stride = stride_reg[DIM-1];
        end else begin : gen_stride_zero
            assign stride = '0;
        end

        if (IS_DIV) begin : gen_divide
            logic [CFG_W-1:0]   rem_in;
            logic [INDEX_W-1:0] trial;
            logic [INDEX_W:0]   diff;

            // A new dimension starts from a zero remainder; its dividend is
            // the quotient left by the previous dimension.
            assign rem_in   = (STEP == 0) ? '0 : rem_prev;
            assign trial    = {rem_in, dq_prev[INDEX_W-1]};
            assign diff     = {1'b0, trial} - {2'b00, divisor};
            assign rem_next = diff[INDEX_W] ? trial[CFG_W-1:0] : diff[CFG_W-1:0];
            assign dq_next  = {dq_prev[INDEX_W-2:0], !diff[INDEX_W]};
        end else begin : gen_pass
            assign rem_next = rem_prev;
            assign dq_next  = dq_prev;
        end

        if (IS_PROD) begin : gen_mult
            logic [2*CFG_W-1:0] full_prod;

            assign full_prod = rem_prev * stride;
            assign prod_next = full_prod[INDEX_W-1:0];
        end else begin : gen_hold_prod
            assign prod_next = prod_prev;
        end

        if (IS_ADD) begin : gen_add
            assign acc_next = acc_prev + prod_prev;
        end else begin : gen_hold_acc
            assign acc_next = acc_prev;
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                rem_reg[k]  <= rem_next;
                dq_reg[k]   <= dq_next;
                prod_reg[k] <= prod_next;
                acc_reg[k]  <= acc_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register with a one-word skid register. The skid fills only
    // when a finished word arrives while the output word is stalled; while
    // it is full the pipeline is frozen.
    // ------------------------------------------------------------------
    logic pipe_push;
    logic out_pop;

    assign pipe_push = pipe_en && valid_reg[STAGES-1];
    assign out_pop   = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (out_pop) begin
                    out_data_reg   <= skid_data_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (pipe_push) begin
                if (!out_valid_reg || out_pop) begin
                    out_data_reg  <= acc_reg[STAGES-1];
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_data_reg  <= acc_reg[STAGES-1];
                    skid_valid_reg <= 1'b1;
                end
            end else if (out_pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_src_index = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BSO_ASSERT_NEVER(a_skid_without_out, aclk, aresetn, skid_valid_reg && !out_valid_reg)
    `BSO_ASSERT(a_skid_fills_on_stall, aclk, aresetn,
                $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready))
    `BSO_ASSERT(a_frozen_pipe_holds, aclk, aresetn, !s_ready |=> $stable(valid_reg))
    `BSO_ASSERT(a_out_from_last_stage, aclk, aresetn,
                $rose(out_valid_reg) |-> $past(valid_reg[STAGES-1]))

endmodule

FILE: verif/broadcast_source_offset_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for broadcast_source_offset: random and directed output
// indices over many tensor shapes, with a scoreboard that predicts each source index.
// Depends on bso_pkg and on the block's RTL only.

// Keeps a mirror of the extent and stride registers and a queue of the source
// indices still owed by the block, oldest first.
class src_index_board;
    bit [bso_pkg::CFG_W-1:0]   extent [bso_pkg::REG_DIMS];
    bit [bso_pkg::CFG_W-1:0]   stride [bso_pkg::REG_DIMS];
    bit [bso_pkg::INDEX_W-1:0] pending [$];
    int                        failures;

    function new();
        for (int d = 0; d < bso_pkg::REG_DIMS; d++) begin
            extent[d] = 1;
            stride[d] = 0;
        end
        failures = 0;
    endfunction

    function void set_register(bit [bso_pkg::CFG_IDX_W-1:0] idx,
                               bit [bso_pkg::CFG_W-1:0] value);
        if (idx < bso_pkg::CFG_STRIDE_BASE)
            extent[idx - bso_pkg::CFG_EXTENT_BASE] = value;
        else if (idx < bso_pkg::CFG_LIMIT)
            stride[idx - bso_pkg::CFG_STRIDE_BASE] = value;
    endfunction

    // Peel coordinates off the running index, innermost dimension first, and
    // sum coordinate times stride with 32-bit wraparound. A zero extent acts
    // as one; whatever quotient is left after the last dimension is dropped.
    function bit [bso_pkg::INDEX_W-1:0] source_of(bit [bso_pkg::INDEX_W-1:0] out_index);
        bit [31:0] rest;
        bit [31:0] ext;
        bit [31:0] str;
        bit [31:0] coord;
        bit [31:0] prod;
        bit [31:0] acc;
        rest = out_index;
        acc  = '0;
        for (int d = 0; d < bso_pkg::NUM_DIMS; d++) begin
            ext = (d < bso_pkg::REG_DIMS) ? {1'b0, extent[d]} : 32'd1;
            str = (d < bso_pkg::REG_DIMS) ? {1'b0, stride[d]} : 32'd0;
            if (ext == 0)
                ext = 1;
            coord = rest % ext;
            rest  = rest / ext;
            prod  = coord * str;
            acc   = acc + prod;
        end
        return acc;
    endfunction

    function void note_word(bit [bso_pkg::INDEX_W-1:0] out_index);
        pending.push_back(source_of(out_index));
    endfunction

    function void check_result(logic [bso_pkg::INDEX_W-1:0] got);
        bit [bso_pkg::INDEX_W-1:0] want;
        if (pending.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("src_index %h arrived with nothing expected", got);
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            failures++;
            if (failures <= 10)
                $display("src_index mismatch: expected %h, got %h", want, got);
        end
    endfunction

    function void close_out();
        if (pending.size() != 0) begin
            $display("%0d source indices never arrived", pending.size());
            failures += pending.size();
        end
    endfunction
endclass

module broadcast_source_offset_test;
    import bso_pkg::*;

    // Long enough for the pipeline, the output register and the skid register
    // to fill and push back on the input side.
    localparam int HOLD_CYCLES    = 500;
    // Cycles to wait after the last expected word, a bit above the latency.
    localparam int DRAIN_CYCLES   = NUM_DIMS * 32 + 20;
    localparam int RANDOM_PHASES  = 10;
    localparam int PRESSURE_PHASE = 2;
    localparam int CALM_PHASE     = 5;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_wr_index;
    logic [CFG_W-1:0]     cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [INDEX_W-1:0]   s_out_index;
    logic                 m_valid;
    logic                 m_ready;
    logic [INDEX_W-1:0]   m_src_index;

    src_index_board board;
    // When set, neither side inserts idle cycles.
    bit                   calm;
    // Raised by the stimulus to ask the result side for one long hold-off.
    bit                   hold_request;
    // Number of elements in the current output tensor, saturated at 2^33.
    longint               shape_volume;

    broadcast_source_offset dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_out_index  (s_out_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_src_index  (m_src_index)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Most gaps are zero or a few cycles; now and then a long one.
    function automatic int idle_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Extents: small shapes most of the time so that in-range indices walk
    // through every dimension; wide phases also use large and maximum extents.
    // Zero shows up too, since the block must treat it as one.
    function automatic bit [CFG_W-1:0] rand_extent(bit wide);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (!wide || r < 60)
            return CFG_W'($urandom_range(1, 12));
        if (r < 90)
            return CFG_W'($urandom() >> $urandom_range(1, 31));
        return '1;
    endfunction

    // Strides: broadcast (zero), small, full-range and near-maximum values,
    // the last two making the products and the sum wrap.
    function automatic bit [CFG_W-1:0] rand_stride();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return '0;
        if (r < 60)
            return CFG_W'($urandom_range(1, 64));
        if (r < 85)
            return CFG_W'($urandom() >> 1);
        return CFG_W'(31'h7FFF_FFFF - $urandom_range(0, 3));
    endfunction

    // Mostly indices inside the tensor, some at its last element and one past
    // it, and the rest anywhere in the 32-bit range so the dropped quotient
    // and every index bit get exercised.
    function automatic bit [INDEX_W-1:0] pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (shape_volume <= 64'h1_0000_0000) begin
            if (r < 70)
                return $urandom_range(0, 32'(shape_volume - 1));
            if (r < 80)
                return 32'(shape_volume - 1 + $urandom_range(0, 1));
        end
        return $urandom();
    endfunction

    // One register write; called at a falling edge, returns at the next one.
    task automatic write_register(input bit [CFG_IDX_W-1:0] idx,
                                  input bit [CFG_W-1:0] value);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(posedge aclk);
        board.set_register(idx, value);
        @(negedge aclk);
    endtask

    // Writes all eight registers for a new tensor shape. Only called while
    // the pipeline is empty.
    task automatic program_shape(input bit [CFG_W-1:0] e0, e1, e2, e3,
                                 input bit [CFG_W-1:0] s0, s1, s2, s3);
        bit [CFG_W-1:0] ext [REG_DIMS];
        bit [CFG_W-1:0] str [REG_DIMS];
        ext = '{e0, e1, e2, e3};
        str = '{s0, s1, s2, s3};
        shape_volume = 1;
        for (int d = 0; d < REG_DIMS; d++) begin
            write_register(CFG_EXTENT_BASE + CFG_IDX_W'(d), ext[d]);
            write_register(CFG_STRIDE_BASE + CFG_IDX_W'(d), str[d]);
            if (d < NUM_DIMS && ext[d] != 0)
                shape_volume = shape_volume * longint'(ext[d]);
            if (shape_volume > 64'h2_0000_0000)
                shape_volume = 64'h2_0000_0000;
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Offers one word, holding it until accepted. Called at a falling edge and
    // returns at the falling edge after acceptance, so back-to-back calls keep
    // valid high without lowering it in between unless an idle gap is drawn.
    task automatic send_word(input bit [INDEX_W-1:0] idx);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_out_index <= idx;
        do
            @(posedge aclk);
        while (!s_ready);
        board.note_word(idx);
        @(negedge aclk);
    endtask

    // Waits until every expected word has come back; returns at a falling edge.
    task automatic wait_drain();
        while (board.pending.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Result side: random ready pattern, plus one long hold-off on request.
    // The hold-off is counted here so that the stimulus keeps offering words
    // meanwhile and the block has to stall its input.
    initial begin
        int gap;
        bit held;
        m_ready = 1'b0;
        held    = 1'b0;
        @(negedge aclk);
        forever begin
            if (hold_request && !held) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                held = 1'b1;
            end else begin
                gap = idle_len();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
    end

    // Every word taken from the result channel is checked against the oldest
    // prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_src_index);
    end

    initial begin
        #7_200_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int n_words;
        board        = new();
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = '0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_out_index  = '0;
        calm         = 1'b0;
        hold_request = 1'b0;
        shape_volume = 1;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Straight out of reset every extent is one and every stride zero, so
        // any index must map to source index zero.
        send_word('0);
        send_word('1);
        send_word(32'h1234_5678);
        s_valid <= 1'b0;
        wait_drain();

        // A 6x5x4x3 tensor with the second dimension broadcast. Covers the
        // first carry, the last element, one past the end (the quotient is
        // dropped) and far-out indices.
        program_shape(3, 4, 5, 6, 1, 0, 3, 15);
        send_word(0);
        send_word(1);
        send_word(2);
        send_word(3);
        send_word(5);
        send_word(359);
        send_word(360);
        send_word('1);
        send_word(32'h8000_0000);
        s_valid <= 1'b0;
        wait_drain();

        // Zero extents on the outer and inner dimensions, a maximum extent in
        // between, and maximum strides so that the products and the sum can wrap.
        program_shape('0, '1, 2, '0, '1, '1, '1, '1);
        send_word('1);
        send_word(32'h7FFF_FFFE);
        send_word(32'h7FFF_FFFF);
        send_word(32'hFFFF_FFFE);
        send_word(5);
        s_valid <= 1'b0;
        wait_drain();

        // Every extent at its maximum: only the two inner dimensions can be
        // reached by a 32-bit index.
        program_shape('1, '1, '1, '1, '1, 1, '1, '1);
        send_word('1);
        send_word(32'h7FFF_FFFF);
        send_word(32'h8000_0000);
        send_word(32'h7FFF_FFFE);
        s_valid <= 1'b0;
        wait_drain();

        // Random shapes, each followed by a run of words. One phase runs with
        // no idling at all and carries the long result-side hold-off; another
        // also runs without gaps.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            calm = (p == PRESSURE_PHASE) || (p == CALM_PHASE);
            program_shape(rand_extent(p[0]), rand_extent(p[0]),
                          rand_extent(p[0]), rand_extent(p[0]),
                          rand_stride(), rand_stride(), rand_stride(), rand_stride());
            n_words = 110;
            if (p == PRESSURE_PHASE) begin
                hold_request = 1'b1;
                n_words      = 300;
            end
            for (int i = 0; i < n_words; i++)
                send_word(pick_index());
            s_valid <= 1'b0;
            wait_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        board.close_out();
        if (board.failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
